/* hdl/dts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dts_pkg
// Shared types and constants of the delayed tone scheduler.
// ----------------------------------------------------------------------------
package dts_pkg;

    // command codes
    localparam logic [1:0] CMD_QUEUE   = 2'd0;
    localparam logic [1:0] CMD_ADVANCE = 2'd1;
    localparam logic [1:0] CMD_CLEAR   = 2'd2;

    // result kinds
    localparam logic KIND_PLAY = 1'b0;
    localparam logic KIND_STOP = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] REG_AUDIO_ENABLE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MASTER_PERCENT = 8'd1;

    localparam int DEF_SLOTS     = 8;
    localparam int MAX_RES       = 8;
    localparam int NRES_W        = $clog2(MAX_RES + 1);
    localparam int US_PER_MS     = 1000;
    localparam int REM_W         = 26;

    // volume scaling: (level * percent + VOL_ROUND) / VOL_DIV, clipped at VOL_MAX
    localparam int VOL_MAX       = 1000;
    localparam int VOL_ROUND     = 50;
    localparam int VOL_DIV       = 100;
    localparam int PROD_W        = 17;
    localparam int RECIP_SHIFT   = 24;
    localparam int RECIP         = ((1 << RECIP_SHIFT) + VOL_DIV - 1) / VOL_DIV;
    localparam int RECIP_W       = 18;
    localparam int QUOT_W        = 11;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  wave_kind;
        logic [15:0] freq_hz;
        logic [15:0] length_ms;
        logic [9:0]  level_per_mille;
        logic [15:0] rise_ms;
        logic [15:0] fall_ms;
        logic [15:0] wait_ms;
        logic [31:0] elapsed_us;
    } t_tone_req;

    typedef struct packed {
        logic        kind;
        logic [2:0]  out_wave;
        logic [15:0] out_freq_hz;
        logic [15:0] out_length_ms;
        logic [9:0]  out_volume;
        logic [15:0] out_rise_ms;
        logic [15:0] out_fall_ms;
        logic        last;
    } t_tone_res;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] wr_data;
    } t_cfg_wr;

endpackage

/* hdl/dts_chan_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dts_chan_if
// Valid/ready channel carrying one payload word per transfer.
// ----------------------------------------------------------------------------
interface dts_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/dts_vol_scale.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dts_vol_scale
// Two-stage volume scaler: rounded percent scaling with clip at full scale.
// ----------------------------------------------------------------------------
module dts_vol_scale (
    input  logic       i_clk,
    input  logic [9:0] i_level,
    input  logic [6:0] i_percent,
    output logic [9:0] o_volume
);
    import dts_pkg::*;

    localparam int FULL_W = PROD_W + RECIP_W;

    logic [PROD_W-1:0] r_prod;
    logic [FULL_W-1:0] w_full;
    logic [QUOT_W-1:0] w_quot;
    logic [9:0]        r_volume;

    // divide by 100 through a reciprocal; exact for every 17-bit dividend
    assign w_full = FULL_W'(r_prod) * FULL_W'(RECIP);
    assign w_quot = w_full[RECIP_SHIFT +: QUOT_W];

    always_ff @(posedge i_clk) begin
        r_prod   <= PROD_W'(i_level) * PROD_W'(i_percent) + PROD_W'(VOL_ROUND);
        r_volume <= (w_quot > QUOT_W'(VOL_MAX)) ? 10'(VOL_MAX) : w_quot[9:0];
    end

    assign o_volume = r_volume;

endmodule

/* hdl/delayed_tone_scheduler_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delayed_tone_scheduler_unit
// Bank of one-shot timer slots that hold tones and release them on expiry.
// ----------------------------------------------------------------------------
// One command is handled at a time; the input is ready only between commands.
// A clear empties the bank and, with audio on, emits a stop-all from the flush
// state. A queue with audio on passes the multiply, divide and place states
// through the two-stage volume scaler, then hands over an immediate tone, or
// walks one slot counter over the bank for the first free slot. An advance
// walks the same counter over all SLOTS slots, one compare-and-subtract per
// cycle unless the scan stalls on a full result register, then hands over
// the final tone. Any command that emits waits only while the result register
// is held by the sink. Results sit in an output register, so the next command
// is taken while the previous final result still waits for its transfer.
// ----------------------------------------------------------------------------
module delayed_tone_scheduler_unit #(
    parameter int SLOTS = dts_pkg::DEF_SLOTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dts_chan_if.sink    i_in,
    dts_chan_if.source  o_out,
    dts_chan_if.sink    i_cfg
);
    import dts_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_PLACE,
        S_FIND,
        S_SCAN,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic [2:0]  wave;
        logic [15:0] freq;
        logic [15:0] length;
        logic [9:0]  volume;
        logic [15:0] rise;
        logic [15:0] fall;
    } t_tone;

    typedef struct packed {
        logic  kind;
        t_tone tone;
    } t_pend;

    function automatic t_tone_res mk_res(input t_pend p, input logic last_flag);
        t_tone_res r;
        r.kind          = p.kind;
        r.out_wave      = p.tone.wave;
        r.out_freq_hz   = p.tone.freq;
        r.out_length_ms = p.tone.length;
        r.out_volume    = p.tone.volume;
        r.out_rise_ms   = p.tone.rise;
        r.out_fall_ms   = p.tone.fall;
        r.last          = last_flag;
        return r;
    endfunction

    // control state
    t_state              r_state;
    logic [IW-1:0]       r_idx;
    logic [NRES_W-1:0]   r_nres;
    logic [SLOTS-1:0]    r_busy;
    logic                r_pend_v;
    logic                r_out_v;
    logic                r_audio;
    logic [6:0]          r_pct;

    // payload
    t_tone_req           r_item;
    logic [REM_W-1:0]    r_delay;
    logic [REM_W-1:0]    r_slot_rem  [SLOTS];
    t_tone               r_slot_tone [SLOTS];
    t_pend               r_pend;
    t_tone_res           r_out;

    logic [9:0]          w_volume;
    t_tone               w_new_tone;
    logic                w_in_fire;
    logic                w_out_free;
    logic                w_cur_busy;
    logic                w_cur_exp;
    logic                w_emit_ok;
    logic                w_scan_stall;
    logic                w_scan_emit;
    logic                w_idx_last;
    logic                w_flush_fire;
    logic                w_find_write;
    logic                w_out_load;

    dts_vol_scale u_vol_scale (
        .i_clk     (i_clk),
        .i_level   (r_item.level_per_mille),
        .i_percent (r_pct),
        .o_volume  (w_volume)
    );

    assign w_new_tone = '{wave:   r_item.wave_kind,
                          freq:   r_item.freq_hz,
                          length: r_item.length_ms,
                          volume: w_volume,
                          rise:   r_item.rise_ms,
                          fall:   r_item.fall_ms};

    assign w_in_fire    = i_in.valid && (r_state == S_IDLE);
    assign w_out_free   = !r_out_v || o_out.ready;
    assign w_cur_busy   = r_busy[r_idx];
    assign w_cur_exp    = 32'(r_slot_rem[r_idx]) <= r_item.elapsed_us;
    assign w_emit_ok    = r_audio && (r_nres < NRES_W'(MAX_RES));
    assign w_idx_last   = (r_idx == IW'(SLOTS - 1));
    // an expiry may only displace the held tone if the result register has room
    assign w_scan_stall = (r_state == S_SCAN) && w_cur_busy && w_cur_exp && w_emit_ok
                          && r_pend_v && !w_out_free;
    assign w_scan_emit  = (r_state == S_SCAN) && !w_scan_stall && w_cur_busy
                          && w_cur_exp && w_emit_ok;
    assign w_flush_fire = (r_state == S_FLUSH) && r_pend_v && w_out_free;
    assign w_find_write = (r_state == S_FIND) && !w_cur_busy;
    // result register takes a new tone
    assign w_out_load   = (w_scan_emit && r_pend_v) || w_flush_fire;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_v;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_nres   <= '0;
            r_busy   <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_audio  <= 1'b1;
            r_pct    <= 7'd100;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.data.reg_index)
                    REG_AUDIO_ENABLE:   r_audio <= i_cfg.data.wr_data[0];
                    REG_MASTER_PERCENT: r_pct   <= i_cfg.data.wr_data;
                    default: ;
                endcase
            end

            if (w_out_load) begin
                r_out_v <= 1'b1;
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        case (i_in.data.cmd)
                            CMD_QUEUE: begin
                                if (r_audio) begin
                                    r_state <= S_MUL;
                                end
                            end
                            CMD_ADVANCE: begin
                                r_idx   <= '0;
                                r_nres  <= '0;
                                r_state <= S_SCAN;
                            end
                            CMD_CLEAR: begin
                                r_busy <= '0;
                                if (r_audio) begin
                                    r_pend_v <= 1'b1;
                                    r_state  <= S_FLUSH;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_MUL: r_state <= S_DIV;
                S_DIV: r_state <= S_PLACE;
                S_PLACE: begin
                    if (r_item.wait_ms == '0) begin
                        r_pend_v <= 1'b1;
                        r_state  <= S_FLUSH;
                    end else begin
                        r_idx   <= '0;
                        r_state <= S_FIND;
                    end
                end
                S_FIND: begin
                    if (!w_cur_busy) begin
                        r_busy[r_idx] <= 1'b1;
                        r_state       <= S_IDLE;
                    end else if (w_idx_last) begin
                        r_state <= S_IDLE;      // bank full, tone dropped
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_SCAN: begin
                    if (!w_scan_stall) begin
                        if (w_cur_busy && w_cur_exp) begin
                            r_busy[r_idx] <= 1'b0;
                        end
                        if (w_scan_emit) begin
                            r_pend_v <= 1'b1;
                            r_nres   <= r_nres + 1'b1;
                        end
                        if (w_idx_last) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_FLUSH: begin
                    if (!r_pend_v) begin
                        r_state <= S_IDLE;
                    end else if (w_out_free) begin
                        r_pend_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_item <= i_in.data;
        end
        if (r_state == S_MUL) begin
            r_delay <= REM_W'(r_item.wait_ms) * REM_W'(US_PER_MS);
        end
        if (r_state == S_PLACE) begin
            r_pend <= '{kind: KIND_PLAY, tone: w_new_tone};
        end
        if (w_in_fire && i_in.data.cmd == CMD_CLEAR) begin
            r_pend <= '{kind: KIND_STOP, tone: '0};
        end
        if (w_find_write) begin
            r_slot_rem[r_idx]  <= r_delay;
            r_slot_tone[r_idx] <= w_new_tone;
        end
        if (r_state == S_SCAN && w_cur_busy && !w_cur_exp) begin
            r_slot_rem[r_idx] <= r_slot_rem[r_idx] - r_item.elapsed_us[REM_W-1:0];
        end
        if (w_scan_emit) begin
            r_pend <= '{kind: KIND_PLAY, tone: r_slot_tone[r_idx]};
            if (r_pend_v) begin
                r_out <= mk_res(r_pend, 1'b0);
            end
        end
        if (w_flush_fire) begin
            r_out <= mk_res(r_pend, 1'b1);
        end
    end

endmodule

/* test/delayed_tone_scheduler_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delayed_tone_scheduler_unit_test
// Self-checking bench for the delayed tone scheduler. A queue-fed driver
// offers commands, a predictor keeps its own copy of the slot bank and the
// two settings, and a monitor compares every emitted tone field by field.
// Directed commands hit full and empty banks, exact expiry, volume clipping
// and muted audio; random commands follow under several settings with
// random gaps on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module delayed_tone_scheduler_unit_test;
    import dts_pkg::*;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int GAP_MAX       = 18;
    localparam int HOLD_CYCLES   = 300;
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'd5;

    logic i_clk;
    logic i_rst_n;

    dts_chan_if #(.T(t_tone_req)) in_ch ();
    dts_chan_if #(.T(t_tone_res)) out_ch ();
    dts_chan_if #(.T(t_cfg_wr))   cfg_ch ();

    delayed_tone_scheduler_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // predictor copy of the settings and the slot bank
    logic        cfg_audio_on = 1'b1;
    logic [6:0]  cfg_pct      = 7'd100;
    logic        bank_busy    [DEF_SLOTS] = '{default: 1'b0};
    logic [31:0] bank_left_us [DEF_SLOTS];
    t_tone_res   bank_tone    [DEF_SLOTS];

    t_tone_req   cmd_pending_q[$];
    t_tone_res   tone_expect_q[$];

    int unsigned err_cnt   = 0;
    int unsigned cycle_cnt = 0;
    int          in_gap_max  = GAP_MAX;
    int          out_gap_max = GAP_MAX;
    int          in_gap_left;
    int          out_stall_left;
    int          hold_left;
    bit          hold_req = 1'b0;
    bit          hold_done;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_cnt++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    function automatic int draw_wait(input int max_wait);
        if (max_wait == 0 || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, max_wait);
    endfunction

    // expected tones for one accepted command; updates the bank copy
    function automatic void predict_tones(input t_tone_req req);
        t_tone_res   res;
        t_tone_res   burst[$];
        int unsigned vol;
        bit          placed;
        res = '0;
        case (req.cmd)
            CMD_QUEUE: begin
                if (cfg_audio_on) begin
                    vol = (32'(req.level_per_mille) * 32'(cfg_pct) + VOL_ROUND) / VOL_DIV;
                    if (vol > VOL_MAX)
                        vol = VOL_MAX;
                    res.kind          = KIND_PLAY;
                    res.out_wave      = req.wave_kind;
                    res.out_freq_hz   = req.freq_hz;
                    res.out_length_ms = req.length_ms;
                    res.out_volume    = 10'(vol);
                    res.out_rise_ms   = req.rise_ms;
                    res.out_fall_ms   = req.fall_ms;
                    if (req.wait_ms == '0) begin
                        burst.push_back(res);
                    end else begin
                        placed = 1'b0;
                        for (int s = 0; s < DEF_SLOTS; s++) begin
                            if (!placed && !bank_busy[s]) begin
                                bank_busy[s]    = 1'b1;
                                bank_left_us[s] = 32'(req.wait_ms) * US_PER_MS;
                                bank_tone[s]    = res;
                                placed          = 1'b1;
                            end
                        end
                    end
                end
            end
            CMD_ADVANCE: begin
                for (int s = 0; s < DEF_SLOTS; s++) begin
                    if (bank_busy[s]) begin
                        if (req.elapsed_us >= bank_left_us[s]) begin
                            bank_busy[s] = 1'b0;
                            if (cfg_audio_on && burst.size() < MAX_RES)
                                burst.push_back(bank_tone[s]);
                        end else begin
                            bank_left_us[s] -= req.elapsed_us;
                        end
                    end
                end
            end
            CMD_CLEAR: begin
                for (int s = 0; s < DEF_SLOTS; s++)
                    bank_busy[s] = 1'b0;
                if (cfg_audio_on) begin
                    res.kind = KIND_STOP;
                    burst.push_back(res);
                end
            end
            default: ;
        endcase
        if (burst.size() > 0)
            burst[burst.size() - 1].last = 1'b1;
        foreach (burst[k])
            tone_expect_q.push_back(burst[k]);
    endfunction

    task automatic check_tone(input t_tone_res got);
        t_tone_res want;
        if (tone_expect_q.size() == 0) begin
            report_mismatch("tone emitted with nothing expected");
        end else begin
            want = tone_expect_q.pop_front();
            check_field("kind",          32'(got.kind),          32'(want.kind));
            check_field("out_wave",      32'(got.out_wave),      32'(want.out_wave));
            check_field("out_freq_hz",   32'(got.out_freq_hz),   32'(want.out_freq_hz));
            check_field("out_length_ms", 32'(got.out_length_ms), 32'(want.out_length_ms));
            check_field("out_volume",    32'(got.out_volume),    32'(want.out_volume));
            check_field("out_rise_ms",   32'(got.out_rise_ms),   32'(want.out_rise_ms));
            check_field("out_fall_ms",   32'(got.out_fall_ms),   32'(want.out_fall_ms));
            check_field("last",          32'(got.last),          32'(want.last));
        end
    endtask

    function automatic void push_cmd(input logic [1:0] c, input logic [2:0] w,
                                     input logic [15:0] f, input logic [15:0] len,
                                     input logic [9:0] lvl, input logic [15:0] rs,
                                     input logic [15:0] fl, input logic [15:0] wt,
                                     input logic [31:0] el);
        t_tone_req r;
        r.cmd             = c;
        r.wave_kind       = w;
        r.freq_hz         = f;
        r.length_ms       = len;
        r.level_per_mille = lvl;
        r.rise_ms         = rs;
        r.fall_ms         = fl;
        r.wait_ms         = wt;
        r.elapsed_us      = el;
        cmd_pending_q.push_back(r);
    endfunction

    function automatic void push_tone(input logic [2:0] w, input logic [15:0] f,
                                      input logic [15:0] len, input logic [9:0] lvl,
                                      input logic [15:0] rs, input logic [15:0] fl,
                                      input logic [15:0] wt);
        push_cmd(CMD_QUEUE, w, f, len, lvl, rs, fl, wt, 32'd0);
    endfunction

    function automatic void push_advance(input logic [31:0] el);
        push_cmd(CMD_ADVANCE, 3'd0, 16'd0, 16'd0, 10'd0, 16'd0, 16'd0, 16'd0, el);
    endfunction

    // mostly short waits and advances so slots fill, expire and overflow
    function automatic t_tone_req random_cmd();
        t_tone_req   r;
        int unsigned pick;
        r.wave_kind       = 3'($urandom);
        r.freq_hz         = 16'($urandom);
        r.length_ms       = 16'($urandom);
        r.rise_ms         = 16'($urandom);
        r.fall_ms         = 16'($urandom);
        r.level_per_mille = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(1001, 1023))
                                                        : 10'($urandom_range(0, 1000));
        r.wait_ms         = 16'($urandom);
        r.elapsed_us      = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            r.cmd = CMD_QUEUE;
            if (pick < 12)
                r.wait_ms = '0;
            else if (pick < 50)
                r.wait_ms = 16'($urandom_range(1, 8));
        end else if (pick < 88) begin
            r.cmd = CMD_ADVANCE;
            if (pick < 84)
                r.elapsed_us = $urandom_range(0, 6000);
        end else if (pick < 96) begin
            r.cmd = CMD_CLEAR;
        end else begin
            r.cmd = CMD_UNKNOWN;
        end
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        t_cfg_wr wr;
        wr.reg_index = idx;
        wr.wr_data   = val;
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= wr;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_AUDIO_ENABLE:   cfg_audio_on = val[0];
            REG_MASTER_PERCENT: cfg_pct      = val;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // block is idle once nothing is pending, offered or expected, plus settle time
    task automatic wait_idle();
        do @(negedge i_clk);
        while (cmd_pending_q.size() != 0 || in_ch.valid || tone_expect_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // command driver
    always @(posedge i_clk) begin
        logic offer;
        int   gap;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_gap_left <= 0;
        end else begin
            offer = in_ch.valid && !in_ch.ready;
            gap   = in_gap_left;
            if (in_ch.valid && in_ch.ready) begin
                predict_tones(in_ch.data);
                gap = draw_wait(in_gap_max);
            end
            if (!offer) begin
                if (gap > 0) begin
                    gap--;
                end else if (cmd_pending_q.size() > 0) begin
                    in_ch.data <= cmd_pending_q.pop_front();
                    offer = 1'b1;
                end
            end
            in_ch.valid <= offer;
            in_gap_left <= gap;
        end
    end

    // long output hold-off, started once on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // tone monitor
    always @(posedge i_clk) begin
        logic rdy;
        int   st;
        if (!i_rst_n) begin
            out_ch.ready   <= 1'b0;
            out_stall_left <= 0;
        end else begin
            st = out_stall_left;
            if (out_ch.valid && out_ch.ready) begin
                check_tone(out_ch.data);
                st = draw_wait(out_gap_max);
            end
            if (hold_left != 0) begin
                rdy = 1'b0;
            end else if (st != 0) begin
                rdy = 1'b0;
                st--;
            end else begin
                rdy = 1'b1;
            end
            out_ch.ready   <= rdy;
            out_stall_left <= st;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        logic [CFG_DATA_W-1:0] phase_en  [6];
        logic [CFG_DATA_W-1:0] phase_pct [6];
        t_tone_req             rq;
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full volume: immediate tones, bank fill, overflow, exact expiry
        write_reg(REG_AUDIO_ENABLE, 7'd1);
        write_reg(REG_MASTER_PERCENT, 7'd100);
        push_tone(3'd7, 16'hFFFF, 16'hFFFF, 10'd1000, 16'hFFFF, 16'hFFFF, 16'd0);
        push_tone(3'd0, 16'h0000, 16'h0000, 10'd0, 16'h0000, 16'h0000, 16'd0);
        push_tone(3'd5, 16'd440, 16'd100, 10'd1023, 16'd10, 16'd20, 16'd0);
        push_tone(3'd1, 16'd1000, 16'd50, 10'd1, 16'd1, 16'd1, 16'd0);
        push_tone(3'd0, 16'd200, 16'd11, 10'd500, 16'd3, 16'd4, 16'd3);
        push_tone(3'd1, 16'd201, 16'd12, 10'd501, 16'd5, 16'd6, 16'd1);
        push_tone(3'd2, 16'd202, 16'd13, 10'd502, 16'd7, 16'd8, 16'd2);
        push_tone(3'd3, 16'd203, 16'd14, 10'd503, 16'd9, 16'd10, 16'hFFFF);
        push_tone(3'd4, 16'd204, 16'd15, 10'd504, 16'd11, 16'd12, 16'd5);
        push_tone(3'd5, 16'd205, 16'd16, 10'd505, 16'd13, 16'd14, 16'd4);
        push_tone(3'd6, 16'd206, 16'd17, 10'd506, 16'd15, 16'd16, 16'd1);
        push_tone(3'd7, 16'd207, 16'd18, 10'd507, 16'd17, 16'd18, 16'd2);
        push_tone(3'd2, 16'd999, 16'd19, 10'd999, 16'd19, 16'd20, 16'd7);  // bank full
        push_advance(32'd999);
        push_advance(32'd1);
        push_advance(32'd0);
        push_advance(32'd4000);
        push_tone(3'd6, 16'h8000, 16'h8000, 10'h200, 16'h8000, 16'h8000, 16'd1);
        push_advance(32'hFFFF_FFFF);
        push_advance(32'd5);
        push_cmd(CMD_UNKNOWN, 3'd7, 16'hFFFF, 16'hFFFF, 10'h3FF, 16'hFFFF, 16'hFFFF,
                 16'hFFFF, 32'hFFFF_FFFF);
        push_tone(3'd3, 16'd300, 16'd30, 10'd300, 16'd3, 16'd3, 16'd10);
        push_cmd(CMD_CLEAR, 3'd0, 16'd0, 16'd0, 10'd0, 16'd0, 16'd0, 16'd0, 32'd0);
        push_advance(32'hFFFF_FFFF);
        wait_idle();

        write_reg(REG_MASTER_PERCENT, 7'd0);
        push_tone(3'd1, 16'd10, 16'd10, 10'd1000, 16'd1, 16'd1, 16'd0);
        push_tone(3'd2, 16'd20, 16'd20, 10'd1023, 16'd2, 16'd2, 16'd0);
        wait_idle();

        // over-range master volume, then slots carried into muted audio
        write_reg(REG_MASTER_PERCENT, 7'd127);
        push_tone(3'd3, 16'd30, 16'd30, 10'd1000, 16'd3, 16'd3, 16'd0);
        push_tone(3'd4, 16'd40, 16'd40, 10'd7, 16'd4, 16'd4, 16'd0);
        push_tone(3'd5, 16'd50, 16'd50, 10'd100, 16'd5, 16'd5, 16'd2);
        push_tone(3'd6, 16'd60, 16'd60, 10'd200, 16'd6, 16'd6, 16'd3);
        push_tone(3'd7, 16'd70, 16'd70, 10'd300, 16'd7, 16'd7, 16'd9);
        wait_idle();

        write_reg(REG_AUDIO_ENABLE, 7'h7E);
        push_tone(3'd1, 16'd11, 16'd11, 10'd11, 16'd11, 16'd11, 16'd0);
        push_tone(3'd2, 16'd22, 16'd22, 10'd22, 16'd22, 16'd22, 16'd1);
        push_advance(32'd2000);
        wait_idle();

        write_reg(REG_AUDIO_ENABLE, 7'd1);
        write_reg(REG_UNMAPPED, 7'd0);
        push_advance(32'd1000);
        push_tone(3'd0, 16'd77, 16'd77, 10'd77, 16'd77, 16'd77, 16'd0);
        wait_idle();

        write_reg(REG_AUDIO_ENABLE, 7'd0);
        push_cmd(CMD_CLEAR, 3'd0, 16'd0, 16'd0, 10'd0, 16'd0, 16'd0, 16'd0, 32'd0);
        wait_idle();
        write_reg(REG_AUDIO_ENABLE, 7'd1);
        push_advance(32'hFFFF_FFFF);
        wait_idle();

        // random traffic under several settings
        phase_en  = '{7'h01, 7'h01, 7'h01, 7'h7E, 7'h01, 7'h03};
        phase_pct = '{7'd100, 7'd0, 7'd127, 7'd55, 7'd100,
                      7'($urandom_range(1, 99))};
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_AUDIO_ENABLE, phase_en[ph]);
            write_reg(REG_MASTER_PERCENT, phase_pct[ph]);
            in_gap_max  = (ph == 2 || ph == 4) ? 0 : GAP_MAX;
            out_gap_max = (ph == 2) ? 0 : GAP_MAX;
            if (ph == 4) begin
                // output held off while immediate tones keep coming
                hold_req = 1'b1;
                repeat (24) begin
                    rq         = random_cmd();
                    rq.cmd     = CMD_QUEUE;
                    rq.wait_ms = '0;
                    cmd_pending_q.push_back(rq);
                end
            end
            repeat (10) cmd_pending_q.push_back(random_cmd());
            wait_idle();
        end

        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* files.f */
hdl/dts_pkg.sv
hdl/dts_chan_if.sv
hdl/dts_vol_scale.sv
hdl/delayed_tone_scheduler_unit.sv
test/delayed_tone_scheduler_unit_test.sv
